>>> hw/rtl/tad_pkg.sv
package tad_pkg;

  // fixed field widths
  localparam int unsigned AXIS_W     = 16;
  localparam int unsigned STEER_W    = 12;
  localparam int unsigned THR_W      = 7;
  localparam int unsigned CONFIRM_W  = 4;
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned SQSUM_W    = 32;
  localparam int unsigned ROOT_STEPS = 16;
  localparam int unsigned VEC_W      = 34;
  localparam int unsigned ZACC_W     = 26;
  localparam int unsigned ATAN_W     = 22;
  localparam int unsigned TABLE_LEN  = 24;
  localparam int unsigned IDX_W      = 5;

  // saturation limit of a Q8.8 angle (90 degrees)
  localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 16'sd23040;

  // register map, word index
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_STEER_CTR = 2'd1;
  localparam logic [1:0] REG_CONFIRM   = 2'd2;

  // register reset values
  localparam logic [THR_W-1:0]     THR_RESET     = 7'd20;
  localparam logic [STEER_W-1:0]   STEER_RESET   = 12'd512;
  localparam logic [CONFIRM_W-1:0] CONFIRM_RESET = 4'd2;

  typedef struct packed {
    logic [THR_W-1:0]     threshold;
    logic [STEER_W-1:0]   steer_center;
    logic [CONFIRM_W-1:0] confirm;
  } tad_cfg_t;

  // atan(2^-i) in units of 2^-16 degree
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    begin
      unique case (idx)
        5'd0:    v = 22'd2949120;
        5'd1:    v = 22'd1740967;
        5'd2:    v = 22'd919879;
        5'd3:    v = 22'd466945;
        5'd4:    v = 22'd234379;
        5'd5:    v = 22'd117304;
        5'd6:    v = 22'd58666;
        5'd7:    v = 22'd29335;
        5'd8:    v = 22'd14668;
        5'd9:    v = 22'd7334;
        5'd10:   v = 22'd3667;
        5'd11:   v = 22'd1833;
        5'd12:   v = 22'd917;
        5'd13:   v = 22'd458;
        5'd14:   v = 22'd229;
        5'd15:   v = 22'd115;
        5'd16:   v = 22'd57;
        5'd17:   v = 22'd29;
        5'd18:   v = 22'd14;
        5'd19:   v = 22'd7;
        5'd20:   v = 22'd4;
        5'd21:   v = 22'd2;
        5'd22:   v = 22'd1;
        default: v = 22'd0;
      endcase
      return v;
    end
  endfunction

endpackage

>>> hw/rtl/tad_lane.sv
module tad_lane
  import tad_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      ack,
  input  logic signed [AXIS_W-1:0]  num,
  input  logic signed [AXIS_W-1:0]  sq_a,
  input  logic signed [AXIS_W-1:0]  sq_b,
  output logic                      done,
  output logic signed [ANGLE_W-1:0] angle
);

  localparam int unsigned N_ITER = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam logic [IDX_W-1:0] LAST_ITER = IDX_W'(N_ITER - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQA  = 3'd1;
  localparam logic [2:0] S_SQB  = 3'd2;
  localparam logic [2:0] S_ROOT = 3'd3;
  localparam logic [2:0] S_ROT  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]                state_r, state_nxt;
  logic signed [AXIS_W-1:0]  num_r, sqa_r, sqb_r;
  logic [SQSUM_W-1:0]        rem_r, rem_nxt;
  logic [SQSUM_W-1:0]        res_r, res_nxt;
  logic [3:0]                rcnt_r, rcnt_nxt;
  logic signed [VEC_W-1:0]   x_r, x_nxt, y_r, y_nxt;
  logic signed [ZACC_W-1:0]  z_r, z_nxt;
  logic [IDX_W-1:0]          icnt_r, icnt_nxt;
  logic                      zero_r, zero_nxt;

  logic signed [AXIS_W-1:0]    mul_op;
  logic signed [2*AXIS_W-1:0]  prod;
  logic [SQSUM_W-1:0]          bit_val;
  logic [SQSUM_W:0]            trial;
  logic signed [VEC_W-1:0]     dx, dy;
  logic signed [ZACC_W-1:0]    step_ang;
  logic signed [ZACC_W-1:0]    z_rnd;
  logic signed [ZACC_W-9:0]    q;

  // shared squaring multiplier
  assign mul_op = (state_r == S_SQA) ? sqa_r : sqb_r;
  assign prod   = mul_op * mul_op;

  // floor square root, one result bit per cycle
  assign bit_val = 32'h4000_0000 >> {rcnt_r, 1'b0};
  assign trial   = {1'b0, res_r} + {1'b0, bit_val};

  // cordic vectoring step
  assign dx       = y_r >>> icnt_r;
  assign dy       = x_r >>> icnt_r;
  assign step_ang = $signed({{(ZACC_W-ATAN_W){1'b0}}, atan_lut(icnt_r)});

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    res_nxt   = res_r;
    rcnt_nxt  = rcnt_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    icnt_nxt  = icnt_r;
    zero_nxt  = zero_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_SQA;
      end
      S_SQA: begin
        rem_nxt   = SQSUM_W'(unsigned'(prod));
        state_nxt = S_SQB;
      end
      S_SQB: begin
        rem_nxt   = rem_r + SQSUM_W'(unsigned'(prod));
        res_nxt   = '0;
        rcnt_nxt  = '0;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        if ({1'b0, rem_r} >= trial) begin
          rem_nxt = rem_r - trial[SQSUM_W-1:0];
          res_nxt = (res_r >> 1) + bit_val;
        end else begin
          res_nxt = res_r >> 1;
        end
        rcnt_nxt = rcnt_r + 4'd1;
        if (rcnt_r == 4'(ROOT_STEPS - 1)) begin
          state_nxt = S_ROT;
        end
      end
      S_ROT: begin
        if (y_r >= 0) begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + step_ang;
        end else begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - step_ang;
        end
        icnt_nxt = icnt_r + 1'b1;
        if (icnt_r == LAST_ITER) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (ack) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // load the vector when the root finishes
    if (state_r == S_ROOT && rcnt_r == 4'(ROOT_STEPS - 1)) begin
      x_nxt    = $signed({{(VEC_W-AXIS_W-14){1'b0}}, res_nxt[AXIS_W-1:0], 14'b0});
      y_nxt    = $signed({{(VEC_W-AXIS_W-14){num_r[AXIS_W-1]}}, num_r, 14'b0});
      z_nxt    = '0;
      icnt_nxt = '0;
      zero_nxt = (res_nxt == '0) && (num_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      num_r <= num;
      sqa_r <= sq_a;
      sqb_r <= sq_b;
    end
    rem_r  <= rem_nxt;
    res_r  <= res_nxt;
    rcnt_r <= rcnt_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    icnt_r <= icnt_nxt;
    zero_r <= zero_nxt;
  end

  // round to q8.8 and saturate
  assign z_rnd = z_r + ZACC_W'(128);
  assign q     = z_rnd[ZACC_W-1:8];

  always_comb begin
    if (zero_r) begin
      angle = '0;
    end else if (q > (ZACC_W-8)'(ANGLE_LIMIT)) begin
      angle = ANGLE_LIMIT;
    end else if (q < -(ZACC_W-8)'(ANGLE_LIMIT)) begin
      angle = -ANGLE_LIMIT;
    end else begin
      angle = q[ANGLE_W-1:0];
    end
  end

  assign done = (state_r == S_DONE);

endmodule

>>> hw/rtl/tad_merge.sv
module tad_merge
  import tad_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      fire,
  input  tad_cfg_t                  cfg,
  input  logic signed [ANGLE_W-1:0] roll,
  input  logic signed [ANGLE_W-1:0] pitch_raw,
  input  logic [STEER_W-1:0]        steer,
  input  logic                      out_tready,
  output logic                      out_tvalid,
  output logic [4*ANGLE_W-1:0]      out_tdata,
  output logic                      free
);

  logic                      out_valid_r;
  logic [4*ANGLE_W-1:0]      out_data_r;
  logic [CONFIRM_W-1:0]      run_r, run_nxt;
  logic signed [ANGLE_W-1:0] held_r, held_nxt;

  logic signed [ANGLE_W-1:0] pitch;
  logic signed [ANGLE_W+1:0] lim;
  logic                      roll_tilt, pitch_tilt;
  logic signed [ANGLE_W-1:0] roll_sym;

  assign pitch = -pitch_raw;
  assign lim   = $signed({3'b000, cfg.threshold, 8'b0});

  assign roll_tilt  = (ANGLE_W+2)'(roll) > lim || (ANGLE_W+2)'(roll) < -lim;
  assign pitch_tilt = (ANGLE_W+2)'(pitch) > lim || (ANGLE_W+2)'(pitch) < -lim;
  assign roll_sym   = (roll_tilt && steer != cfg.steer_center) ? roll : '0;

  // pitch run count and capture
  always_comb begin
    run_nxt  = run_r;
    held_nxt = held_r;
    if (pitch_tilt) begin
      if (run_r != '1) begin
        run_nxt = run_r + 1'b1;
        if (run_nxt == cfg.confirm) held_nxt = pitch;
      end
    end else begin
      run_nxt  = '0;
      held_nxt = '0;
    end
  end

  assign free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      run_r       <= '0;
      held_r      <= '0;
    end else begin
      if (fire) begin
        out_valid_r <= 1'b1;
        run_r       <= run_nxt;
        held_r      <= held_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (fire) out_data_r <= {held_nxt, roll_sym, pitch, roll};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> hw/rtl/accel_tilt_angle_detector.sv
// channel   dir  handshake                     payload
// in        in   in_tvalid / in_tready         accel_x, accel_y, accel_z, steer_position
// out       out  out_tvalid / out_tready       roll_angle, pitch_angle, roll_symptom, pitch_symptom
// cfg       in   psel / penable / pready       threshold, steer center, confirm count
//
// each word passes through the two squarings, the 16-step root and the cordic
// iterations of each lane.
// a new word is taken once the lanes hand their result to the output register,
// which can still be waiting on out_tready.
// reset is synchronous; registers return to their reset values, run state clears.
module accel_tilt_angle_detector
  import tad_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // accel_x, accel_y, accel_z, steer_position, pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // roll_angle, pitch_angle, roll_symptom, pitch_symptom
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tad_cfg_t           cfg_r;
  logic               busy_r;
  logic [STEER_W-1:0] steer_r;
  logic               in_fire, roll_done, pitch_done, fire, free;
  logic signed [ANGLE_W-1:0] roll_ang, pitch_ang;
  logic signed [AXIS_W-1:0]  ax, ay, az;

  assign ax = in_tdata[15:0];
  assign ay = in_tdata[31:16];
  assign az = in_tdata[47:32];

  // register port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold    <= THR_RESET;
      cfg_r.steer_center <= STEER_RESET;
      cfg_r.confirm      <= CONFIRM_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_THRESHOLD: cfg_r.threshold    <= pwdata[THR_W-1:0];
        REG_STEER_CTR: cfg_r.steer_center <= pwdata[STEER_W-1:0];
        REG_CONFIRM:   cfg_r.confirm      <= pwdata[CONFIRM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_THRESHOLD: prdata = {25'b0, cfg_r.threshold};
      REG_STEER_CTR: prdata = {20'b0, cfg_r.steer_center};
      REG_CONFIRM:   prdata = {28'b0, cfg_r.confirm};
      default:       prdata = '0;
    endcase
  end

  // input word acceptance
  assign in_tready = !busy_r;
  assign in_fire   = in_tvalid && in_tready;
  assign fire      = roll_done && pitch_done && free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_fire) begin
      busy_r <= 1'b1;
    end else if (fire) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) steer_r <= in_tdata[59:48];
  end

  // roll lane: atan2(y, sqrt(x^2 + z^2))
  tad_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire),
    .ack   (fire),
    .num   (ay),
    .sq_a  (ax),
    .sq_b  (az),
    .done  (roll_done),
    .angle (roll_ang)
  );

  // pitch lane: atan2(x, sqrt(y^2 + z^2)), negated in the merge
  tad_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire),
    .ack   (fire),
    .num   (ax),
    .sq_a  (ay),
    .sq_b  (az),
    .done  (pitch_done),
    .angle (pitch_ang)
  );

  tad_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .cfg        (cfg_r),
    .roll       (roll_ang),
    .pitch_raw  (pitch_ang),
    .steer      (steer_r),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .free       (free)
  );

endmodule

>>> tb/sv/tb_accel_tilt_angle_detector.sv
module tb_accel_tilt_angle_detector;
  import tad_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STEPS = 16;
  localparam int unsigned CYCLE_LIMIT = 900000;

  typedef struct packed {
    logic [STEER_W-1:0] steer;
    logic signed [AXIS_W-1:0] az;
    logic signed [AXIS_W-1:0] ay;
    logic signed [AXIS_W-1:0] ax;
  } sample_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] pitch_sym;
    logic signed [ANGLE_W-1:0] roll_sym;
    logic signed [ANGLE_W-1:0] pitch;
    logic signed [ANGLE_W-1:0] roll;
  } angles_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  accel_tilt_angle_detector #(.CORDIC_STEPS(STEPS)) dut (.*);

  // predictor copy of registers and tilt state
  logic [THR_W-1:0]     thr_q;
  logic [STEER_W-1:0]   ctr_q;
  logic [CONFIRM_W-1:0] confirm_q;
  logic [3:0]           run_cnt;
  logic signed [15:0]   held_q;

  sample_t pending_words[$];
  angles_t expected_angles[$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycles;
  bit          failed;

  initial begin
    clk = 1'b0;
  end
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint floor_shr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint r;
    longint b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // cordic vectoring, angle in q8.8 degrees
  function automatic int vector_angle(longint num, longint den);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint q;
    x = den * 16384;
    y = num * 16384;
    z = 0;
    if (x == 0 && y == 0) return 0;
    for (int i = 0; i < STEPS && i < TABLE_LEN; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + longint'(atan_lut(i[IDX_W-1:0]));
      end else begin
        x = x - dx; y = y + dy; z = z - longint'(atan_lut(i[IDX_W-1:0]));
      end
    end
    q = floor_shr(z + 128, 8);
    if (q > 23040) q = 23040;
    if (q < -23040) q = -23040;
    return int'(q);
  endfunction

  function automatic bit over_limit(int a);
    int lim;
    lim = int'(thr_q) * 256;
    return a > lim || a < -lim;
  endfunction

  // tilt angles and symptoms for one sample, updating pitch run state
  function automatic angles_t predict_angles(sample_t s);
    angles_t r;
    longint ax;
    longint ay;
    longint az;
    int roll;
    int pitch;
    ax = s.ax; ay = s.ay; az = s.az;
    roll = vector_angle(ay, int_sqrt(ax * ax + az * az));
    pitch = -vector_angle(ax, int_sqrt(ay * ay + az * az));
    if (over_limit(pitch)) begin
      if (run_cnt < 4'd15) begin
        run_cnt = run_cnt + 4'd1;
        if (run_cnt == confirm_q) held_q = pitch[15:0];
      end
    end else begin
      run_cnt = '0;
      held_q = '0;
    end
    r.roll = roll[15:0];
    r.pitch = pitch[15:0];
    r.roll_sym = (over_limit(roll) && s.steer != ctr_q) ? roll[15:0] : 16'sd0;
    r.pitch_sym = held_q;
    return r;
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        sample_t s;
        s = pending_words.pop_front();
        expected_angles.push_back(predict_angles(s));
        in_tvalid <= 1'b1;
        in_tdata <= {4'd0, s};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // output ready and checker
  always @(posedge clk) begin
    angles_t got;
    angles_t want;
    cycles <= cycles + 1;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= $urandom_range(99) >= recv_stall_pct;
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_angles.size() == 0) begin
          $error("result word with no expected angles");
          failed = 1'b1;
        end else begin
          want = expected_angles.pop_front();
          if (got.roll !== want.roll) begin
            $error("roll_angle exp %0d got %0d", want.roll, got.roll); failed = 1'b1;
          end
          if (got.pitch !== want.pitch) begin
            $error("pitch_angle exp %0d got %0d", want.pitch, got.pitch); failed = 1'b1;
          end
          if (got.roll_sym !== want.roll_sym) begin
            $error("roll_symptom exp %0d got %0d", want.roll_sym, got.roll_sym);
            failed = 1'b1;
          end
          if (got.pitch_sym !== want.pitch_sym) begin
            $error("pitch_symptom exp %0d got %0d", want.pitch_sym, got.pitch_sym);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_tvalid || expected_angles.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_THRESHOLD: thr_q = val[THR_W-1:0];
      REG_STEER_CTR: ctr_q = val[STEER_W-1:0];
      default:       confirm_q = val[CONFIRM_W-1:0];
    endcase
  endtask

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 40)) - 16'd20;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s.ax = rand_axis(); s.ay = rand_axis(); s.az = rand_axis();
    s.steer = ($urandom_range(3) == 0) ? ctr_q : 12'($urandom);
    return s;
  endfunction

  // a burst of tilted pitch with random roll, to walk the confirm counter
  task automatic push_tilt_run(int n);
    sample_t s;
    logic signed [15:0] base;
    base = ($urandom_range(1)) ? 16'sd20000 : -16'sd20000;
    for (int i = 0; i < n; i++) begin
      s = rand_sample();
      s.ax = base + 16'($urandom_range(0, 4000));
      s.az = 16'($urandom_range(0, 6000));
      pending_words.push_back(s);
    end
  endtask

  task automatic run_phase(int n, int unsigned idle, int unsigned stall);
    int left;
    int k;
    send_idle_pct = idle; recv_stall_pct = stall;
    left = n;
    while (left > 0) begin
      if ($urandom_range(2) != 0) begin
        k = $urandom_range(1, 18);
        push_tilt_run(k);
        left -= k;
      end else begin
        pending_words.push_back(rand_sample());
        left--;
      end
    end
    wait_drained();
  endtask

  initial begin
    sample_t s;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    send_idle_pct = 0; recv_stall_pct = 0; cycles = 0; failed = 1'b0;
    thr_q = THR_RESET; ctr_q = STEER_RESET; confirm_q = CONFIRM_RESET;
    run_cnt = '0; held_q = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, zero vector, centred steering, pitch held run
    s = '0; pending_words.push_back(s);
    s = '{steer: 12'hfff, az: 16'sh7fff, ay: 16'sh7fff, ax: 16'sh7fff};
    pending_words.push_back(s);
    s = '{steer: 12'h000, az: 16'sh8000, ay: 16'sh8000, ax: 16'sh8000};
    pending_words.push_back(s);
    s = '{steer: 12'd512, az: 16'sd0, ay: 16'sh7fff, ax: 16'sd0};
    pending_words.push_back(s);
    s = '{steer: 12'd513, az: 16'sd0, ay: 16'sh8000, ax: 16'sd0};
    pending_words.push_back(s);
    s = '{steer: 12'd1, az: 16'sd0, ay: 16'sd0, ax: 16'sh8000};
    pending_words.push_back(s);
    for (int i = 0; i < 17; i++) begin
      s = '{steer: 12'd7, az: 16'sd100, ay: 16'sd0, ax: 16'sd16000};
      pending_words.push_back(s);
    end
    s = '{steer: 12'd7, az: 16'sd16000, ay: 16'sd0, ax: 16'sd0};
    pending_words.push_back(s);
    wait_drained();

    // phases with sender idles and receiver stalls at reset settings
    run_phase(200, 0, 0);
    run_phase(150, 87, 0);
    run_phase(150, 0, 87);
    run_phase(150, 22, 22);

    // the sender holds off until all results are in
    wait_drained();

    reg_write(REG_THRESHOLD, 32'd0);
    reg_write(REG_STEER_CTR, 32'd0);
    reg_write(REG_CONFIRM, 32'd1);
    run_phase(200, 22, 22);

    reg_write(REG_THRESHOLD, 32'd90);
    reg_write(REG_STEER_CTR, 32'd4095);
    reg_write(REG_CONFIRM, 32'd15);
    run_phase(150, 0, 0);

    reg_write(REG_THRESHOLD, 32'd127);
    reg_write(REG_CONFIRM, 32'd0);
    run_phase(100, 22, 22);

    reg_write(REG_THRESHOLD, 32'd45);
    reg_write(REG_STEER_CTR, 32'd2730);
    reg_write(REG_CONFIRM, 32'd10);
    run_phase(200, 0, 0);

    reg_write(REG_THRESHOLD, 32'd5);
    reg_write(REG_STEER_CTR, 32'd1365);
    reg_write(REG_CONFIRM, 32'd4);
    run_phase(200, 87, 87);

    if (!failed) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
